// ===== hdl/sroe_pkg.sv =====
// ----------------------------------------------------------------------------
// sroe_pkg
// Shared types and codes for the shift register output expander.
// ----------------------------------------------------------------------------
package sroe_pkg;

	// Byte index width covers 32 stages, beyond the largest supported chain (15 bytes).
	localparam int IDX_W = 5;
	typedef logic [IDX_W-1:0] idx_t;

	// Input actions
	localparam logic [2:0] ACT_WRITE_BIT = 3'd0;
	localparam logic [2:0] ACT_WRITE_ALL = 3'd1;
	localparam logic [2:0] ACT_COMMIT    = 3'd2;
	localparam logic [2:0] ACT_FLUSH     = 3'd3;
	localparam logic [2:0] ACT_TICK      = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_PIN    = 2'd0;
	localparam logic [1:0] KIND_SERIAL = 2'd1;
	localparam logic [1:0] KIND_BLINK  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_DIRECT_PINS  = 2'd0;
	localparam logic [1:0] REG_CHAIN_BYTES  = 2'd1;
	localparam logic [1:0] REG_LINK_PRESENT = 2'd2;
	localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
	localparam int RESULT_LIMIT = 8;

	// One byte write into the working or the transmit bytes
	typedef struct packed {
		logic       en;
		logic       tx;
		idx_t       idx;
		logic [7:0] data;
	} byte_wr_t;

endpackage

// ===== hdl/shift_register_output_expander_core.sv =====
// ----------------------------------------------------------------------------
// shift_register_output_expander_core
// Direct output pins plus a double-buffered chain of 8-bit shift registers.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one command; busy rises on the
// next cycle and stays high until the command is done. Results come out one
// per cycle on the result ports, each valid for the single cycle that strobe
// is high, and the receiver cannot stall them; last marks the final result of
// a command. A small sequencer walks the byte banks through one shared byte
// read/modify/write path, one byte or one pin per cycle: write-all reports
// the direct pins and then fills the chain bytes, commit copies the working
// bytes into the transmit bank, and flush sends the transmit bytes, highest
// stage first (results are capped at 8).
// Write configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module shift_register_output_expander_core #(
	parameter int MAX_CHAIN_BYTES = 8,
	parameter int MAX_DIRECT_PINS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  port,
	input  logic [7:0]  level,
	input  logic        from_interrupt,
	input  logic [31:0] now,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// results
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [2:0]  pin_index,
	output logic        pin_high,
	output logic [7:0]  serial_byte,
	output logic        last,
	output logic        blink_level
);
	import sroe_pkg::*;

	localparam logic [4:0] DMAX = (MAX_DIRECT_PINS > 15) ? 5'd15 : 5'(MAX_DIRECT_PINS);
	localparam logic [4:0] CMAX = (MAX_CHAIN_BYTES > 15) ? 5'd15 : 5'(MAX_CHAIN_BYTES);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_PINS   = 6'b000100,
		ST_FILL   = 6'b001000,
		ST_COPY   = 6'b010000,
		ST_SEND   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [3:0]  direct_pins_q;
	logic [3:0]  chain_bytes_q;
	logic        link_q;
	logic [31:0] period_q;

	// captured command
	logic [2:0]  action_q;
	logic [7:0]  port_q;
	logic [7:0]  level_q;
	logic        irq_q;
	logic [31:0] now_q;

	// block state
	logic        change_q, change_d;
	logic        flush_q, flush_d;
	logic        blink_q, blink_d;
	logic [31:0] stamp_q, stamp_d;

	// sequencer counters
	logic [3:0]  cnt_q, cnt_d;
	logic [2:0]  sent_q, sent_d;

	// result register
	logic        strobe_q;
	logic [1:0]  kind_q;
	logic [2:0]  pin_q;
	logic        high_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        blevel_q;

	logic        emit;
	logic [1:0]  e_kind;
	logic [2:0]  e_pin;
	logic        e_high;
	logic [7:0]  e_byte;
	logic        e_last;
	logic        e_blink;

	byte_wr_t    wr;
	idx_t        rd_idx;
	logic [7:0]  rd_work;
	logic [7:0]  rd_tx;

	logic [3:0]  nd;
	logic [3:0]  nc;
	logic [7:0]  off;
	logic [7:0]  cur_byte;
	logic        cur_bit;
	logic [7:0]  mask;
	logic [7:0]  fill_val;
	logic [31:0] elapsed;

	assign nd = ({1'b0, direct_pins_q} > DMAX) ? DMAX[3:0] : direct_pins_q;
	assign nc = ({1'b0, chain_bytes_q} > CMAX) ? CMAX[3:0] : chain_bytes_q;

	assign off      = port_q - {4'd0, nd};
	assign cur_byte = irq_q ? rd_tx : rd_work;
	assign cur_bit  = cur_byte[off[2:0]];
	assign mask     = 8'd1 << off[2:0];
	assign fill_val = (level_q == 8'd1) ? BYTE_ALL_ONES : level_q;
	assign elapsed  = now_q - stamp_q;

	sroe_byte_store #(
		.DEPTH(MAX_CHAIN_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd_work(rd_work),
		.rd_tx  (rd_tx)
	);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		sent_d   = sent_q;
		change_d = change_q;
		flush_d  = flush_q;
		blink_d  = blink_q;
		stamp_d  = stamp_q;
		wr       = '0;
		rd_idx   = '0;
		emit     = 1'b0;
		e_kind   = KIND_PIN;
		e_pin    = '0;
		e_high   = 1'b0;
		e_byte   = '0;
		e_last   = 1'b0;
		e_blink  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
				sent_d  = '0;
				case (action_q)
					ACT_WRITE_BIT: begin
						rd_idx = off[7:3];
						if (nc != 4'd0 || nd != 4'd0) begin
							if (port_q < {4'd0, nd}) begin
								emit   = 1'b1;
								e_pin  = port_q[2:0];
								e_high = (level_q != 8'd0);
								e_last = 1'b1;
							end else if (link_q && off < {1'b0, nc, 3'b000}
									&& level_q != {7'd0, cur_bit}) begin
								// levels other than 0 and 1 only mark the bank as changed
								wr.en   = (level_q == 8'd0) || (level_q == 8'd1);
								wr.tx   = irq_q;
								wr.idx  = off[7:3];
								wr.data = (level_q == 8'd0) ? (cur_byte & ~mask)
								                            : (cur_byte | mask);
								if (irq_q) begin
									flush_d = 1'b1;
								end else begin
									change_d = 1'b1;
								end
							end
						end
					end
					ACT_WRITE_ALL: begin
						if (nc != 4'd0 || nd != 4'd0) begin
							if (link_q) begin
								if (irq_q) begin
									flush_d = 1'b1;
								end else begin
									change_d = 1'b1;
								end
							end
							if (nd != 4'd0) begin
								state_d = ST_PINS;
							end else if (link_q) begin
								state_d = ST_FILL;
							end
						end
					end
					ACT_COMMIT: begin
						if (change_q && link_q) begin
							flush_d = 1'b1;
							if (nc != 4'd0) begin
								state_d = ST_COPY;
							end
						end
					end
					ACT_FLUSH: begin
						if (flush_q) begin
							flush_d = 1'b0;
							if (link_q && nc != 4'd0) begin
								cnt_d   = nc;
								state_d = ST_SEND;
							end
						end
					end
					ACT_TICK: begin
						emit   = 1'b1;
						e_kind = KIND_BLINK;
						e_last = 1'b1;
						if (elapsed > period_q) begin
							blink_d = ~blink_q;
							stamp_d = now_q;
						end
						e_blink = blink_d;
					end
					default: begin
					end
				endcase
			end
			ST_PINS: begin
				emit   = 1'b1;
				e_pin  = cnt_q[2:0];
				e_high = (level_q != 8'd0);
				e_last = (cnt_q == nd - 4'd1) || (cnt_q == 4'(RESULT_LIMIT - 1));
				cnt_d  = cnt_q + 4'd1;
				if (e_last) begin
					cnt_d   = '0;
					state_d = (link_q && nc != 4'd0) ? ST_FILL : ST_IDLE;
				end
			end
			ST_FILL: begin
				wr.en   = 1'b1;
				wr.tx   = irq_q;
				wr.idx  = {1'b0, cnt_q};
				wr.data = fill_val;
				cnt_d   = cnt_q + 4'd1;
				if (cnt_q == nc - 4'd1 || nc == 4'd0) begin
					state_d = ST_IDLE;
				end
			end
			ST_COPY: begin
				rd_idx  = {1'b0, cnt_q};
				wr.en   = 1'b1;
				wr.tx   = 1'b1;
				wr.idx  = {1'b0, cnt_q};
				wr.data = rd_work;
				cnt_d   = cnt_q + 4'd1;
				if (cnt_q == nc - 4'd1) begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				// highest stage first
				rd_idx = {1'b0, cnt_q - 4'd1};
				emit   = 1'b1;
				e_kind = KIND_SERIAL;
				e_byte = rd_tx;
				e_last = (cnt_q == 4'd1) || (sent_q == 3'(RESULT_LIMIT - 1));
				cnt_d  = cnt_q - 4'd1;
				sent_d = sent_q + 3'd1;
				if (e_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			sent_q   <= '0;
			change_q <= 1'b1;
			flush_q  <= 1'b0;
			blink_q  <= 1'b0;
			stamp_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			sent_q   <= sent_d;
			change_q <= change_d;
			flush_q  <= flush_d;
			blink_q  <= blink_d;
			stamp_q  <= stamp_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_pins_q <= '0;
			chain_bytes_q <= '0;
			link_q        <= 1'b1;
			period_q      <= 32'd250;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECT_PINS:  direct_pins_q <= cfg_wdata[3:0];
				REG_CHAIN_BYTES:  chain_bytes_q <= cfg_wdata[3:0];
				REG_LINK_PRESENT: link_q        <= cfg_wdata[0];
				REG_BLINK_PERIOD: period_q      <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// command capture, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			action_q <= action;
			port_q   <= port;
			level_q  <= level;
			irq_q    <= from_interrupt;
			now_q    <= now;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q   <= e_kind;
			pin_q    <= e_pin;
			high_q   <= e_high;
			byte_q   <= e_byte;
			last_q   <= e_last;
			blevel_q <= e_blink;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign pin_index   = pin_q;
	assign pin_high    = high_q;
	assign serial_byte = byte_q;
	assign last        = last_q;
	assign blink_level = blevel_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("result burst broken before last");

	a_blink_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_BLINK |-> last)
		else $error("blink report not marked last");
`endif

endmodule

// ===== hdl/sroe_byte_store.sv =====
// ----------------------------------------------------------------------------
// sroe_byte_store
// Working and transmit byte banks: one byte write per cycle, one shared read
// index that returns the byte of each bank.
// ----------------------------------------------------------------------------
module sroe_byte_store #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sroe_pkg::byte_wr_t wr,
	input  sroe_pkg::idx_t    rd_idx,
	output logic [7:0]        rd_work,
	output logic [7:0]        rd_tx
);
	import sroe_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] work_q [DEPTH];
	logic [7:0] tx_q   [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				work_q[i] <= '0;
				tx_q[i]   <= '0;
			end
		end else if (wr.en) begin
			if (wr.tx) begin
				tx_q[wr.idx[IW-1:0]] <= wr.data;
			end else begin
				work_q[wr.idx[IW-1:0]] <= wr.data;
			end
		end
	end

	assign rd_work = work_q[rd_idx[IW-1:0]];
	assign rd_tx   = tx_q[rd_idx[IW-1:0]];

endmodule
